// ===== rtl/core/cc_pkg.sv =====
// shared types and constants of the cycle crossover block
// no dependencies

package cc_pkg;

    localparam int CITY_W          = 6;
    localparam int MAX_CITIES_DEF  = 64;

    typedef enum logic [6:0] {
        S_LOAD  = 7'b0000001,
        S_WB    = 7'b0000010,
        S_WP    = 7'b0000100,
        S_WA    = 7'b0001000,
        S_WC    = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_DRAIN = 7'b1000000
    } t_state;

    typedef struct packed {
        logic load;
        logic walk_init;
        logic step;
        logic set_ok;
        logic set_bad;
        logic sel_emit;
        logic emit_rd;
        logic pair_done;
    } t_dp_cmd;

    typedef struct packed {
        logic load_full;
        logic step_fail;
        logic step_home;
        logic len_limit;
        logic emit_last;
    } t_dp_stat;

endpackage

// ===== rtl/core/cycle_crossover_top.sv =====
// top level of the cycle crossover block
// depends on cc_pkg, cc_ctrl and cc_datapath

// cycle crossover of two parent tours
//
// input channel: a word is taken at a rising edge with start high and busy
//   low; each word carries one position of both parents plus a last flag
// loading takes one cycle per word with busy low, so words may follow
//   back to back; a word marked last, or the MAX_CITIES-th word, closes
//   the pair and raises busy
// the cycle walk then handles each position on the cycle through the
//   chain of three registered store reads (parent b, city index,
//   parent a) and the decision state
// emission gives one result word per stored position on consecutive
//   cycles, each shown for one cycle under o_strobe, last_out on the final
//   one; results come out through the registered store reads and the result register
// busy stays high from the closing word of a pair through walk and
//   emission and falls in the cycle of the final result, so the next
//   pair can load at once
// the receiver cannot stall: results are not held
// reset returns to loading with an empty gene count; the cycle mask is
//   cleared at the start of every walk, and the parent stores need no
//   clearing
module cycle_crossover_top #(
    parameter int MAX_CITIES = cc_pkg::MAX_CITIES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [cc_pkg::CITY_W-1:0] i_parent_a_city,
    input  logic [cc_pkg::CITY_W-1:0] i_parent_b_city,
    input  logic                      i_last_gene,
    output logic                      o_strobe,
    output logic [cc_pkg::CITY_W-1:0] o_child_a_city,
    output logic [cc_pkg::CITY_W-1:0] o_child_b_city,
    output logic                      o_degenerate,
    output logic                      o_invalid,
    output logic                      o_last_out
);

    // command and status between sequencer and datapath
    cc_pkg::t_dp_cmd  cmd;
    cc_pkg::t_dp_stat stat;

    cc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_last_gene (i_last_gene),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .busy        (busy)
    );

    cc_datapath #(
        .MAX_CITIES (MAX_CITIES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_parent_a_city (i_parent_a_city),
        .i_parent_b_city (i_parent_b_city),
        .o_strobe        (o_strobe),
        .o_child_a_city  (o_child_a_city),
        .o_child_b_city  (o_child_b_city),
        .o_degenerate    (o_degenerate),
        .o_invalid       (o_invalid),
        .o_last_out      (o_last_out)
    );

endmodule

// ===== rtl/core/cc_ctrl.sv =====
// sequencer of the cycle crossover block: load, walk, emit
// depends on cc_pkg

module cc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             i_last_gene,
    input  cc_pkg::t_dp_stat i_stat,
    output cc_pkg::t_dp_cmd  o_cmd,
    output logic             busy
);

    cc_pkg::t_state r_state;
    cc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cc_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != cc_pkg::S_LOAD);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            cc_pkg::S_LOAD: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    if (i_last_gene || i_stat.load_full) begin
                        o_cmd.walk_init = 1'b1;
                        n_state         = cc_pkg::S_WB;
                    end
                end
            end
            cc_pkg::S_WB: n_state = cc_pkg::S_WP;
            cc_pkg::S_WP: n_state = cc_pkg::S_WA;
            cc_pkg::S_WA: n_state = cc_pkg::S_WC;
            cc_pkg::S_WC: begin
                o_cmd.step = 1'b1;
                priority if (i_stat.step_fail) begin
                    o_cmd.set_bad = 1'b1;
                    n_state       = cc_pkg::S_EMIT;
                end else if (i_stat.step_home) begin
                    o_cmd.set_ok = 1'b1;
                    n_state      = cc_pkg::S_EMIT;
                end else if (i_stat.len_limit) begin
                    o_cmd.set_bad = 1'b1;
                    n_state       = cc_pkg::S_EMIT;
                end else begin
                    n_state = cc_pkg::S_WB;
                end
            end
            cc_pkg::S_EMIT: begin
                o_cmd.sel_emit = 1'b1;
                o_cmd.emit_rd  = 1'b1;
                if (i_stat.emit_last) begin
                    n_state = cc_pkg::S_DRAIN;
                end
            end
            cc_pkg::S_DRAIN: begin
                o_cmd.pair_done = 1'b1;
                n_state         = cc_pkg::S_LOAD;
            end
            default: n_state = cc_pkg::S_LOAD;
        endcase
    end

endmodule

// ===== rtl/core/cc_datapath.sv =====
// parent stores, city index, cycle mask, walk registers and result register
// depends on cc_pkg

module cc_datapath #(
    parameter int MAX_CITIES = cc_pkg::MAX_CITIES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cc_pkg::t_dp_cmd           i_cmd,
    output cc_pkg::t_dp_stat          o_stat,
    input  logic [cc_pkg::CITY_W-1:0] i_parent_a_city,
    input  logic [cc_pkg::CITY_W-1:0] i_parent_b_city,
    output logic                      o_strobe,
    output logic [cc_pkg::CITY_W-1:0] o_child_a_city,
    output logic [cc_pkg::CITY_W-1:0] o_child_b_city,
    output logic                      o_degenerate,
    output logic                      o_invalid,
    output logic                      o_last_out
);

    localparam int IW      = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
    localparam int CW      = $clog2(MAX_CITIES + 1);
    localparam int NCITIES = 2 ** cc_pkg::CITY_W;

    // stores
    logic [cc_pkg::CITY_W-1:0] r_first  [MAX_CITIES];
    logic [cc_pkg::CITY_W-1:0] r_second [MAX_CITIES];
    logic [IW-1:0]             r_pos    [NCITIES];
    logic [MAX_CITIES-1:0]     r_mask;

    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_len;
    logic [IW-1:0] r_cur;
    logic [IW-1:0] r_k;
    logic          r_ok;
    logic          r_degen;

    // registered read data
    logic [cc_pkg::CITY_W-1:0] r_a_q;
    logic [cc_pkg::CITY_W-1:0] r_b_q;
    logic [IW-1:0]             r_pos_q;
    logic                      r_mask_q;

    logic r_v1;
    logic r_last1;

    logic [IW-1:0] addr_a;
    logic [IW-1:0] addr_b;
    logic [CW-1:0] n_len;
    logic [CW-1:0] cnt_inc;

    assign addr_a  = i_cmd.sel_emit ? r_k : r_pos_q;
    assign addr_b  = i_cmd.sel_emit ? r_k : r_cur;
    assign n_len   = r_len + CW'(1);
    assign cnt_inc = r_cnt + CW'(1);

    always_comb begin
        o_stat.load_full = (cnt_inc == CW'(MAX_CITIES));
        o_stat.step_fail = (CW'(r_pos_q) >= r_cnt) || (r_a_q != r_b_q);
        o_stat.step_home = (r_pos_q == '0);
        o_stat.len_limit = (n_len >= r_cnt);
        o_stat.emit_last = ((CW'(r_k) + CW'(1)) == r_cnt);
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_first[r_cnt[IW-1:0]]  <= i_parent_a_city;
            r_second[r_cnt[IW-1:0]] <= i_parent_b_city;
            r_pos[i_parent_a_city]  <= r_cnt[IW-1:0];
        end
        r_a_q   <= r_first[addr_a];
        r_b_q   <= r_second[addr_b];
        r_pos_q <= r_pos[r_b_q];
    end

    // control counters and cycle mask
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_mask <= '0;
            r_v1   <= 1'b0;
        end else begin
            if (i_cmd.pair_done) begin
                r_cnt <= '0;
            end else if (i_cmd.load) begin
                r_cnt <= cnt_inc;
            end
            if (i_cmd.walk_init) begin
                r_mask <= '0;
            end else if (i_cmd.step) begin
                r_mask[r_cur] <= 1'b1;
            end
            r_v1 <= i_cmd.emit_rd;
        end
    end

    // walk and emit registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_cur <= '0;
            r_len <= '0;
            r_k   <= '0;
        end else begin
            if (i_cmd.step) begin
                r_cur <= r_pos_q;
                r_len <= n_len;
            end
            if (i_cmd.emit_rd) begin
                r_k <= r_k + IW'(1);
            end
        end
        if (i_cmd.set_ok) begin
            r_ok    <= 1'b1;
            r_degen <= (n_len == CW'(1)) || (n_len == r_cnt);
        end else if (i_cmd.set_bad) begin
            r_ok    <= 1'b0;
            r_degen <= 1'b0;
        end
        r_mask_q <= r_mask[r_k];
        r_last1  <= o_stat.emit_last;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ok || r_mask_q) begin
            o_child_a_city <= r_a_q;
            o_child_b_city <= r_b_q;
        end else begin
            o_child_a_city <= r_b_q;
            o_child_b_city <= r_a_q;
        end
        o_degenerate <= r_degen;
        o_invalid    <= !r_ok;
        o_last_out   <= r_last1;
    end

endmodule
